// ----- hw/rtl/tst_pkg.sv -----
package tst_pkg;

    localparam int TST_TABLE_ENTRIES = 1024;
    localparam int TST_BUCKET_W = 10;
    localparam int TST_CFG_INDEX_W = 3;
    localparam int TST_CFG_DATA_W = 16;
    localparam int TST_EVICT_W = 11;
    localparam logic [31:0] TST_SWEEP_INTERVAL = 32'd10;

    localparam logic [TST_CFG_INDEX_W-1:0] CFG_DROP_UNKNOWN = 3'd0;
    localparam logic [TST_CFG_INDEX_W-1:0] CFG_TO_INITIAL = 3'd1;
    localparam logic [TST_CFG_INDEX_W-1:0] CFG_TO_ESTABLISHED = 3'd2;
    localparam logic [TST_CFG_INDEX_W-1:0] CFG_TO_CONNECTION = 3'd3;
    localparam logic [TST_CFG_INDEX_W-1:0] CFG_TO_CLOSING = 3'd4;

    localparam logic KIND_PACKET = 1'b0;
    localparam logic KIND_SWEEP = 1'b1;

    localparam logic [7:0] FLG_FIN = 8'h01;
    localparam logic [7:0] FLG_SYN = 8'h02;
    localparam logic [7:0] FLG_RST = 8'h04;
    localparam logic [7:0] FLG_PSH = 8'h08;
    localparam logic [7:0] FLG_ACK = 8'h10;
    localparam logic [7:0] FLG_URG = 8'h20;

    localparam logic [2:0] TRK_NEW = 3'd0;
    localparam logic [2:0] TRK_SYN_RECEIVED = 3'd1;
    localparam logic [2:0] TRK_ESTABLISHED = 3'd2;
    localparam logic [2:0] TRK_CLOSING = 3'd3;
    localparam logic [2:0] TRK_LAST_ACK = 3'd4;
    localparam logic [2:0] TRK_CLOSED = 3'd5;

    localparam logic [1:0] CLS_INITIAL = 2'd0;
    localparam logic [1:0] CLS_ESTABLISHED = 2'd1;
    localparam logic [1:0] CLS_CONNECTION = 2'd2;
    localparam logic [1:0] CLS_CLOSING = 2'd3;

    typedef struct packed {
        logic        valid;
        logic [31:0] src_ip;
        logic [31:0] dst_ip;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [2:0]  trk;
        logic [1:0]  cls;
        logic [31:0] last_seen;
    } t_entry;

    typedef enum logic [1:0] {
        FSM_CLEAR,
        FSM_IDLE,
        FSM_PKT,
        FSM_SWEEP
    } t_fsm;

endpackage

// ----- hw/rtl/tcp_session_tracker.sv -----
// Channel   Handshake            Payload
// command   i_start / o_busy     i_kind, i_bucket, i_src_ip, i_dst_ip, i_src_port,
//                                i_dst_port, i_tcp_flags, i_now_sec
// result    o_valid (strobe)     o_drop, o_hit, o_created, o_deleted,
//                                o_session_state, o_evicted_count
// config    i_cfg_we             i_cfg_index, i_cfg_wdata
//
// A packet reads its bucket from the table RAM, then updates and writes it back in
// FSM_PKT; its result is shown in the cycle after that.
// A sweep that runs walks the whole table; one that does not run gives its result
// in the next cycle.
// After reset a clearing pass zeroes every entry of the table RAM; o_busy
// is high meanwhile. Configuration writes are taken in any cycle.
// The receiver cannot stall: each result is shown for exactly one cycle.
module tcp_session_tracker
    import tst_pkg::*;
#(
    parameter int TABLE_ENTRIES = TST_TABLE_ENTRIES
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    output logic                       o_busy,
    input  logic                       i_kind,
    input  logic [TST_BUCKET_W-1:0]    i_bucket,
    input  logic [31:0]                i_src_ip,
    input  logic [31:0]                i_dst_ip,
    input  logic [15:0]                i_src_port,
    input  logic [15:0]                i_dst_port,
    input  logic [7:0]                 i_tcp_flags,
    input  logic [31:0]                i_now_sec,
    input  logic                       i_cfg_we,
    input  logic [TST_CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [TST_CFG_DATA_W-1:0]  i_cfg_wdata,
    output logic                       o_valid,
    output logic                       o_drop,
    output logic                       o_hit,
    output logic                       o_created,
    output logic                       o_deleted,
    output logic [2:0]                 o_session_state,
    output logic [TST_EVICT_W-1:0]     o_evicted_count
);

    localparam int AW = $clog2(TABLE_ENTRIES);
    localparam int LW = $clog2(TABLE_ENTRIES + 1);
    localparam int RW = (AW > TST_BUCKET_W) ? AW : TST_BUCKET_W;
    localparam int RED_STEPS = 7;
    localparam int EW = $bits(t_entry);
    localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_ENTRIES - 1);

    t_fsm r_fsm, n_fsm;
    logic [AW-1:0] r_cnt, n_cnt;
    logic [LW-1:0] r_live, n_live;
    logic [31:0] r_last_sweep, n_last_sweep;
    logic [TST_EVICT_W-1:0] r_evict, n_evict;

    logic r_drop_unknown;
    logic [15:0] r_to_initial, r_to_established, r_to_connection, r_to_closing;

    logic [AW-1:0] r_idx, n_idx;
    logic [31:0] r_src_ip, n_src_ip, r_dst_ip, n_dst_ip;
    logic [15:0] r_src_port, n_src_port, r_dst_port, n_dst_port;
    logic [7:0] r_flags, n_flags;
    logic [31:0] r_now, n_now;

    logic r_o_valid, n_o_valid;
    logic r_o_drop, n_o_drop, r_o_hit, n_o_hit;
    logic r_o_created, n_o_created, r_o_deleted, n_o_deleted;
    logic [2:0] r_o_state, n_o_state;
    logic [TST_EVICT_W-1:0] r_o_evict, n_o_evict;

    logic [RW-1:0] red;
    logic [AW-1:0] idx_in;
    logic sweep_go;

    logic ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [EW-1:0] ram_wdata, ram_rdata;

    t_entry ent, new_ent, upd;
    logic match;
    logic [7:0] flg;
    logic [2:0] cur;
    logic del;
    logic [15:0] limit;
    logic [31:0] age;
    logic evict;

    tst_ram #(
        .WIDTH(EW),
        .DEPTH(TABLE_ENTRIES)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    // Bucket modulo table size by restoring compare and subtract steps.
    always_comb begin
        red = RW'(i_bucket);
        for (int k = RED_STEPS - 1; k >= 0; k--) begin
            if ((TABLE_ENTRIES << k) < (1 << TST_BUCKET_W)) begin
                if (red >= RW'(TABLE_ENTRIES << k)) begin
                    red = red - RW'(TABLE_ENTRIES << k);
                end
            end
        end
    end

    assign idx_in = red[AW-1:0];
    assign sweep_go = ((i_now_sec - r_last_sweep) > TST_SWEEP_INTERVAL) && (r_live != '0);

    assign ent = t_entry'(ram_rdata);
    assign match = ent.valid && (ent.src_ip == r_src_ip) && (ent.dst_ip == r_dst_ip)
                   && (ent.src_port == r_src_port) && (ent.dst_port == r_dst_port);
    assign flg = r_flags & ~(FLG_PSH | FLG_URG);

    always_comb begin
        new_ent.valid = 1'b1;
        new_ent.src_ip = r_src_ip;
        new_ent.dst_ip = r_dst_ip;
        new_ent.src_port = r_src_port;
        new_ent.dst_port = r_dst_port;
        new_ent.trk = TRK_NEW;
        new_ent.cls = CLS_INITIAL;
        new_ent.last_seen = r_now;
    end

    always_comb begin
        case (ent.cls)
            CLS_INITIAL:     limit = r_to_initial;
            CLS_ESTABLISHED: limit = r_to_established;
            CLS_CONNECTION:  limit = r_to_connection;
            default:         limit = r_to_closing;
        endcase
    end

    assign age = r_now - ent.last_seen;
    assign evict = ent.valid && (age > {16'd0, limit});

    // Tracking state step for a hit.
    always_comb begin
        upd = ent;
        upd.last_seen = r_now;
        cur = ent.trk;
        del = 1'b0;
        case (ent.trk)
            TRK_NEW: begin
                if (flg == (FLG_SYN | FLG_ACK)) begin
                    cur = TRK_SYN_RECEIVED;
                end else if (flg == FLG_RST) begin
                    del = 1'b1;
                end
            end
            TRK_SYN_RECEIVED: begin
                if (flg == FLG_ACK) begin
                    cur = TRK_ESTABLISHED;
                    upd.cls = CLS_ESTABLISHED;
                end
            end
            TRK_ESTABLISHED: begin
                if (flg == FLG_FIN || flg == (FLG_FIN | FLG_ACK)) begin
                    cur = TRK_CLOSING;
                    upd.cls = CLS_CLOSING;
                end else begin
                    upd.cls = CLS_CONNECTION;
                end
            end
            TRK_CLOSING: begin
                if (flg == FLG_FIN || flg == (FLG_FIN | FLG_ACK) || flg == FLG_RST) begin
                    cur = TRK_LAST_ACK;
                end
            end
            TRK_LAST_ACK: begin
                if (flg == FLG_ACK) begin
                    cur = TRK_CLOSED;
                    del = 1'b1;
                end
            end
            default: begin
            end
        endcase
        if (del) begin
            upd.valid = 1'b0;
        end else begin
            upd.trk = cur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm <= FSM_CLEAR;
        end else begin
            r_fsm <= n_fsm;
        end
    end

    always_comb begin
        n_fsm = r_fsm;
        n_cnt = r_cnt;
        n_live = r_live;
        n_last_sweep = r_last_sweep;
        n_evict = r_evict;
        n_idx = r_idx;
        n_src_ip = r_src_ip;
        n_dst_ip = r_dst_ip;
        n_src_port = r_src_port;
        n_dst_port = r_dst_port;
        n_flags = r_flags;
        n_now = r_now;
        n_o_valid = 1'b0;
        n_o_drop = r_o_drop;
        n_o_hit = r_o_hit;
        n_o_created = r_o_created;
        n_o_deleted = r_o_deleted;
        n_o_state = r_o_state;
        n_o_evict = r_o_evict;
        ram_we = 1'b0;
        ram_waddr = r_cnt;
        ram_wdata = '0;
        ram_raddr = idx_in;
        case (r_fsm)
            FSM_CLEAR: begin
                ram_we = 1'b1;
                if (r_cnt == LAST_ADDR) begin
                    n_cnt = '0;
                    n_fsm = FSM_IDLE;
                end else begin
                    n_cnt = r_cnt + AW'(1);
                end
            end
            FSM_IDLE: begin
                if (i_start) begin
                    n_idx = idx_in;
                    n_src_ip = i_src_ip;
                    n_dst_ip = i_dst_ip;
                    n_src_port = i_src_port;
                    n_dst_port = i_dst_port;
                    n_flags = i_tcp_flags;
                    n_now = i_now_sec;
                    if (i_kind == KIND_PACKET) begin
                        n_fsm = FSM_PKT;
                    end else if (sweep_go) begin
                        ram_raddr = '0;
                        n_cnt = '0;
                        n_evict = '0;
                        n_last_sweep = i_now_sec;
                        n_fsm = FSM_SWEEP;
                    end else begin
                        n_o_valid = 1'b1;
                        n_o_drop = 1'b0;
                        n_o_hit = 1'b0;
                        n_o_created = 1'b0;
                        n_o_deleted = 1'b0;
                        n_o_state = TRK_NEW;
                        n_o_evict = '0;
                    end
                end
            end
            FSM_PKT: begin
                ram_waddr = r_idx;
                ram_raddr = r_idx;
                n_o_valid = 1'b1;
                n_o_drop = 1'b0;
                n_o_hit = match;
                n_o_created = 1'b0;
                n_o_deleted = 1'b0;
                n_o_state = TRK_NEW;
                n_o_evict = '0;
                if (r_flags == FLG_SYN || (!match && !r_drop_unknown)) begin
                    ram_we = 1'b1;
                    ram_wdata = new_ent;
                    n_o_created = 1'b1;
                    if (!ent.valid) begin
                        n_live = r_live + LW'(1);
                    end
                end else if (!match) begin
                    n_o_drop = 1'b1;
                end else begin
                    ram_we = 1'b1;
                    ram_wdata = upd;
                    n_o_deleted = del;
                    n_o_state = cur;
                    if (del && r_live != '0) begin
                        n_live = r_live - LW'(1);
                    end
                end
                n_fsm = FSM_IDLE;
            end
            FSM_SWEEP: begin
                ram_raddr = r_cnt + AW'(1);
                if (evict) begin
                    ram_we = 1'b1;
                    ram_wdata = {1'b0, ram_rdata[EW-2:0]};
                    if (r_live != '0) begin
                        n_live = r_live - LW'(1);
                    end
                    if (r_evict != {TST_EVICT_W{1'b1}}) begin
                        n_evict = r_evict + TST_EVICT_W'(1);
                    end
                end
                if (r_cnt == LAST_ADDR) begin
                    n_cnt = '0;
                    n_o_valid = 1'b1;
                    n_o_drop = 1'b0;
                    n_o_hit = 1'b0;
                    n_o_created = 1'b0;
                    n_o_deleted = 1'b0;
                    n_o_state = TRK_NEW;
                    n_o_evict = n_evict;
                    n_fsm = FSM_IDLE;
                end else begin
                    n_cnt = r_cnt + AW'(1);
                end
            end
            default: begin
                n_fsm = FSM_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_live <= '0;
            r_last_sweep <= '0;
            r_evict <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            r_live <= n_live;
            r_last_sweep <= n_last_sweep;
            r_evict <= n_evict;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        r_src_ip <= n_src_ip;
        r_dst_ip <= n_dst_ip;
        r_src_port <= n_src_port;
        r_dst_port <= n_dst_port;
        r_flags <= n_flags;
        r_now <= n_now;
        r_o_drop <= n_o_drop;
        r_o_hit <= n_o_hit;
        r_o_created <= n_o_created;
        r_o_deleted <= n_o_deleted;
        r_o_state <= n_o_state;
        r_o_evict <= n_o_evict;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drop_unknown <= 1'b0;
            r_to_initial <= 16'd30;
            r_to_established <= 16'd3600;
            r_to_connection <= 16'd3600;
            r_to_closing <= 16'd60;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_DROP_UNKNOWN:   r_drop_unknown <= i_cfg_wdata[0];
                CFG_TO_INITIAL:     r_to_initial <= i_cfg_wdata;
                CFG_TO_ESTABLISHED: r_to_established <= i_cfg_wdata;
                CFG_TO_CONNECTION:  r_to_connection <= i_cfg_wdata;
                CFG_TO_CLOSING:     r_to_closing <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    assign o_busy = (r_fsm != FSM_IDLE);
    assign o_valid = r_o_valid;
    assign o_drop = r_o_drop;
    assign o_hit = r_o_hit;
    assign o_created = r_o_created;
    assign o_deleted = r_o_deleted;
    assign o_session_state = r_o_state;
    assign o_evicted_count = r_o_evict;

endmodule

// ----- hw/rtl/tst_ram.sv -----
module tst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/tst_checker.sv -----
module tst_checker
    import tst_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_start,
    input logic                   i_kind,
    input logic                   o_busy,
    input logic                   o_valid,
    input logic                   o_drop,
    input logic                   o_hit,
    input logic                   o_created,
    input logic                   o_deleted,
    input logic [2:0]             o_session_state,
    input logic [TST_EVICT_W-1:0] o_evicted_count
);

    // A packet transfer gives its result after the FSM_PKT state, when o_valid is registered.
    a_pkt_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && i_kind == KIND_PACKET) |=> ##1 o_valid)
        else $error("packet result missing");

    a_pkt_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && i_kind == KIND_PACKET) |=> o_busy)
        else $error("busy low while a packet is in work");

    a_drop_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_drop) |-> (!o_hit && !o_created && !o_deleted
                                 && o_session_state == TRK_NEW))
        else $error("dropped packet reports session activity");

    a_evict_sweep_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_drop || o_hit || o_created || o_deleted)) |-> (o_evicted_count == '0))
        else $error("packet result carries an eviction count");

    a_delete_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_deleted) |-> (o_hit && !o_created))
        else $error("deletion without a matching session");

endmodule

bind tcp_session_tracker tst_checker u_tst_checker (.*);
